@@ design/w2s_pkg.sv @@
// ----------------------------------------------------------------------------
// w2s_pkg
// Types, constants and helpers shared by the world-to-screen projection.
// ----------------------------------------------------------------------------
package w2s_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned ClipW    = 51;
  localparam int unsigned MagW     = 50;
  localparam int unsigned QuoW     = 66;
  localparam int unsigned DivSteps = 66;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages = DivSteps / StepsPerStage;

  localparam logic [CfgW-1:0] RegReset [NumRegs] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  localparam logic signed [CoordW+1:0] OneQ16 = 34'sd65536;
  localparam logic [MagW-1:0] RatioCap = MagW'(64'd1 << 48);

  typedef struct packed {
    logic signed [CoordW-1:0] world_x;
    logic signed [CoordW-1:0] world_y;
    logic signed [CoordW-1:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
    logic                     w_zero;
  } out_item_t;

  // One divider lane: running remainder, quotient bits, operand magnitude.
  typedef struct packed {
    logic [MagW-1:0] den;
    logic [MagW:0]   rem;
    logic [QuoW-1:0] quo;
  } div_lane_t;

  // Item context that rides alongside the divider lanes.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic w_zero;
  } div_ctx_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [MagW+2:0] v);
    if (v > (MagW+3)'(64'sd2147483647))
      return 32'sh7fffffff;
    else if (v < -(MagW+3)'(64'sd2147483648))
      return 32'sh80000000;
    else
      return v[CoordW-1:0];
  endfunction

endpackage

@@ design/world_to_screen_projection.sv @@
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Projects a world point through a 4x4 matrix to normalized screen space.
// ----------------------------------------------------------------------------
// A point is accepted every cycle while the output side takes results. Each
// item passes through registered stages in order: the matrix products, the row
// sums, the divider stages (two quotient bits per stage) and the output
// register, which also does the screen mapping. The whole pipeline advances
// when its output slot is free or being emptied.
module world_to_screen_projection (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  w2s_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output w2s_pkg::out_item_t           out_item,
  input  logic                         cfg_we,
  input  logic [w2s_pkg::RegIdxW:0]    cfg_index,
  input  logic [w2s_pkg::CfgW-1:0]     cfg_data
);
  import w2s_pkg::*;

  logic [CfgW-1:0] mat [NumRegs];
  logic            en;
  logic            c_valid, d_valid, m_valid;
  logic signed [ClipW-1:0] cx, cy, cw;
  div_ctx_t        dctx;
  logic [MagW-1:0] qx, qy;
  out_item_t       m_item;
  logic signed [MagW+2:0] rx, ry, hx, hy;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) mat[i] <= RegReset[i];
    end else if (cfg_we && !cfg_index[RegIdxW]) begin
      mat[cfg_index[RegIdxW-1:0]] <= cfg_data;
    end
  end

  w2s_clip u_clip (
    .clk, .rst, .en, .in_valid, .in_item, .mat,
    .out_valid(c_valid), .cx, .cy, .cw
  );

  w2s_div u_div (
    .clk, .rst, .en, .in_valid(c_valid), .cx, .cy, .cw,
    .out_valid(d_valid), .out_ctx(dctx), .qx, .qy
  );

  always_comb begin
    rx = dctx.neg_x ? -(MagW+3)'(qx) : (MagW+3)'(qx);
    ry = dctx.neg_y ? -(MagW+3)'(qy) : (MagW+3)'(qy);
    hx = (rx + (MagW+3)'(OneQ16)) >>> 1;
    hy = (ry + (MagW+3)'(OneQ16)) >>> 1;
    m_item.w_zero = dctx.w_zero;
    if (dctx.w_zero) begin
      m_item.screen_x = '0;
      m_item.screen_y = '0;
    end else begin
      m_item.screen_x = sat32(hx);
      m_item.screen_y = sat32((MagW+3)'(OneQ16) - hy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= d_valid;
    end
    if (en) out_item <= m_item;
  end

  assign out_valid = m_valid;
endmodule

@@ design/w2s_clip.sv @@
// ----------------------------------------------------------------------------
// w2s_clip
// Two-stage matrix transform: products, then row sums for clip x, y and w.
// ----------------------------------------------------------------------------
module w2s_clip (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  w2s_pkg::in_item_t             in_item,
  input  logic [w2s_pkg::CfgW-1:0]      mat [w2s_pkg::NumRegs],
  output logic                          out_valid,
  output logic signed [w2s_pkg::ClipW-1:0] cx,
  output logic signed [w2s_pkg::ClipW-1:0] cy,
  output logic signed [w2s_pkg::ClipW-1:0] cw
);
  import w2s_pkg::*;

  logic signed [CoordW-1:0] pt [3];
  logic signed [CoordW-1:0] coef [3][4];
  logic signed [2*CoordW-1:0] prod [3][3];
  logic signed [CoordW-1:0] bias [3];
  logic                      p_valid;
  logic signed [ClipW-1:0]  sum [3];

  localparam int RowSel [3] = '{0, 1, 3};

  always_comb begin
    pt[0] = in_item.world_x;
    pt[1] = in_item.world_y;
    pt[2] = in_item.world_z;
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = mat[2*RowSel[r]][31:0];
      coef[r][1] = mat[2*RowSel[r]][63:32];
      coef[r][2] = mat[2*RowSel[r]+1][31:0];
      coef[r][3] = mat[2*RowSel[r]+1][63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        bias[r] <= coef[r][3];
        for (int c = 0; c < 3; c++) prod[r][c] <= coef[r][c] * pt[c];
      end
      for (int r = 0; r < 3; r++) begin
        sum[r] <= ClipW'(bias[r]) + ClipW'(prod[r][0] >>> 16)
                + ClipW'(prod[r][1] >>> 16) + ClipW'(prod[r][2] >>> 16);
      end
    end
  end

  assign cx = sum[0];
  assign cy = sum[1];
  assign cw = sum[2];
endmodule

@@ design/w2s_div.sv @@
// ----------------------------------------------------------------------------
// w2s_div
// Pipelined restoring divider for both ratios, two quotient bits per stage.
// ----------------------------------------------------------------------------
module w2s_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [w2s_pkg::ClipW-1:0] cx,
  input  logic signed [w2s_pkg::ClipW-1:0] cy,
  input  logic signed [w2s_pkg::ClipW-1:0] cw,
  output logic                             out_valid,
  output w2s_pkg::div_ctx_t                out_ctx,
  output logic [w2s_pkg::MagW-1:0]         qx,
  output logic [w2s_pkg::MagW-1:0]         qy
);
  import w2s_pkg::*;

  // Numerator magnitude shifted up by 16 is fed MSB first.
  localparam int unsigned NumW = MagW + 16;

  logic                vld [DivStages+1];
  div_ctx_t            ctx [DivStages+1];
  div_lane_t           lx [DivStages+1];
  div_lane_t           ly [DivStages+1];
  logic [NumW-1:0]     nx [DivStages+1];
  logic [NumW-1:0]     ny [DivStages+1];

  function automatic logic [MagW-1:0] mag(input logic signed [ClipW-1:0] v);
    logic [ClipW-1:0] a;
    a = v[ClipW-1] ? ClipW'(-v) : v;
    return MagW'(a);
  endfunction

  function automatic div_lane_t step(input div_lane_t l, input logic b);
    div_lane_t o;
    logic [MagW+1:0] t;
    o = l;
    t = {l.rem, b};
    if (t >= {2'b0, l.den}) begin
      t = t - {2'b0, l.den};
      o.quo = {l.quo[QuoW-2:0], 1'b1};
    end else begin
      o.quo = {l.quo[QuoW-2:0], 1'b0};
    end
    o.rem = t[MagW:0];
    return o;
  endfunction

  always_comb begin
    vld[0]     = in_valid;
    ctx[0]     = '{neg_x: cx[ClipW-1] ^ cw[ClipW-1], neg_y: cy[ClipW-1] ^ cw[ClipW-1],
                   w_zero: (cw == '0)};
    lx[0]      = '{den: (cw == '0) ? MagW'(1) : mag(cw), rem: '0, quo: '0};
    ly[0]      = lx[0];
    nx[0]      = {mag(cx), 16'd0};
    ny[0]      = {mag(cy), 16'd0};
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    div_lane_t ax, ay;
    always_comb begin
      ax = step(step(lx[s], nx[s][NumW-1]), nx[s][NumW-2]);
      ay = step(step(ly[s], ny[s][NumW-1]), ny[s][NumW-2]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        ctx[s+1] <= ctx[s];
        lx[s+1]  <= ax;
        ly[s+1]  <= ay;
        nx[s+1]  <= {nx[s][NumW-3:0], 2'b00};
        ny[s+1]  <= {ny[s][NumW-3:0], 2'b00};
      end
    end
  end

  function automatic logic [MagW-1:0] cap(input logic [QuoW-1:0] q);
    if (q > QuoW'(RatioCap)) return RatioCap;
    return q[MagW-1:0];
  endfunction

  assign out_valid = vld[DivStages];
  assign out_ctx   = ctx[DivStages];
  assign qx        = cap(lx[DivStages].quo);
  assign qy        = cap(ly[DivStages].quo);
endmodule

@@ design/w2s_checker.sv @@
// ----------------------------------------------------------------------------
// w2s_checker
// Port-level checks on the projection block.
// ----------------------------------------------------------------------------
module w2s_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input w2s_pkg::out_item_t out_item
);
  import w2s_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.w_zero |-> out_item.screen_x == '0 && out_item.screen_y == '0)
    else $error("zero w gave nonzero coordinates");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result item right after reset");
endmodule

bind world_to_screen_projection w2s_checker u_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .out_item
);

@@ verif/world_to_screen_projection_test.sv @@
// ----------------------------------------------------------------------------
// World-to-screen projection testbench
// Drives world points through the projection block under several matrix
// settings and handshake pressures, and compares every screen result with a
// fixed-point prediction of the clip transform, divide and screen mapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module world_to_screen_projection_test;
  import w2s_pkg::*;

  class projection_scoreboard;
    logic [CfgW-1:0] matrix_regs [NumRegs];
    out_item_t       pending_screen [$];
    int              fail_count;

    function new();
      for (int i = 0; i < NumRegs; i++) matrix_regs[i] = RegReset[i];
      fail_count = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [CfgW-1:0] val);
      if (idx < NumRegs) matrix_regs[idx] = val;
    endfunction

    function longint entry(int r, int c);
      logic [CfgW-1:0] reg_val;
      logic signed [31:0] half;
      reg_val = matrix_regs[r * 2 + c / 2];
      half = (c % 2) ? reg_val[63:32] : reg_val[31:0];
      return longint'(half);
    endfunction

    function longint clip_row(int r, longint pt [3]);
      longint acc;
      acc = entry(r, 3);
      for (int c = 0; c < 3; c++) acc += (entry(r, c) * pt[c]) >>> 16;
      return acc;
    endfunction

    function longint ratio(longint n, longint d);
      logic [63:0] un, ud, ip, rem, quo;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      ip = un / ud;
      rem = un % ud;
      if (ip >= 64'h1_0000_0000) begin
        quo = 64'd1 << 48;
      end else begin
        quo = ip;
        for (int i = 0; i < 16; i++) begin
          rem = rem << 1;
          quo = quo << 1;
          if (rem >= ud) begin
            rem = rem - ud;
            quo[0] = 1'b1;
          end
        end
        if (quo > (64'd1 << 48)) quo = 64'd1 << 48;
      end
      return ((n < 0) != (d < 0)) ? -longint'(quo) : longint'(quo);
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_point(in_item_t pt_in);
      longint pt [3];
      longint cx, cy, cw;
      out_item_t res;
      pt[0] = longint'(pt_in.world_x);
      pt[1] = longint'(pt_in.world_y);
      pt[2] = longint'(pt_in.world_z);
      cx = clip_row(0, pt);
      cy = clip_row(1, pt);
      cw = clip_row(3, pt);
      res = '0;
      if (cw == 0) begin
        res.w_zero = 1'b1;
      end else begin
        res.screen_x = clamp32((ratio(cx, cw) + 65536) >>> 1);
        res.screen_y = clamp32(65536 - ((ratio(cy, cw) + 65536) >>> 1));
      end
      pending_screen.push_back(res);
    endfunction

    function void check_screen(out_item_t got);
      out_item_t exp_res;
      if (pending_screen.size() == 0) begin
        $error("unexpected result %h", got);
        fail_count++;
        return;
      end
      exp_res = pending_screen.pop_front();
      if (got.screen_x !== exp_res.screen_x) begin
        $error("screen_x expected %h actual %h", exp_res.screen_x, got.screen_x);
        fail_count++;
      end
      if (got.screen_y !== exp_res.screen_y) begin
        $error("screen_y expected %h actual %h", exp_res.screen_y, got.screen_y);
        fail_count++;
      end
      if (got.w_zero !== exp_res.w_zero) begin
        $error("w_zero expected %b actual %b", exp_res.w_zero, got.w_zero);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;
  logic               cfg_we;
  logic [RegIdxW:0]   cfg_index;
  logic [CfgW-1:0]    cfg_data;

  projection_scoreboard board;
  int send_idle_pct;
  int recv_stall_pct;

  world_to_screen_projection i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_screen(out_item);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_point(in_item_t pt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= pt;
    do @(posedge clk); while (!in_ready);
    board.note_point(pt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_screen.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(int unsigned idx, logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx[RegIdxW:0];
    cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'(int'($urandom_range(20 * 65536)) - 10 * 65536);
      default: return 32'(int'($urandom_range(2047)) - 1024);
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'(int'($urandom_range(4 * 65536)) - 2 * 65536);
      2: return 32'(int'($urandom_range(64)) - 32);
      default: return '0;
    endcase
  endfunction

  task automatic random_points(int count);
    in_item_t pt;
    int mode;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(2);
      pt.world_x = rand_coord(mode);
      pt.world_y = rand_coord(mode);
      pt.world_z = rand_coord(mode);
      send_point(pt);
    end
  endtask

  initial begin
    logic [31:0] edge_vals [6];
    in_item_t pt;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    edge_vals = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h10000, 32'hffff0000};
    for (int i = 0; i < 6; i++) begin
      pt.world_x = edge_vals[i];
      pt.world_y = edge_vals[(i + 2) % 6];
      pt.world_z = edge_vals[(i + 4) % 6];
      send_point(pt);
    end
    drain();

    // Zero w: last row all zero; then negative w and extreme entries.
    write_reg(6, '0);
    write_reg(7, '0);
    for (int i = 0; i < 3; i++) begin
      pt = {edge_vals[i], edge_vals[i + 1], edge_vals[i + 2]};
      send_point(pt);
    end
    drain();
    write_reg(7, {32'hffff0000, 32'h0});
    write_reg(0, {32'h7fffffff, 32'h80000000});
    write_reg(1, {32'h7fffffff, 32'h80000000});
    for (int i = 0; i < 6; i++) begin
      pt = {edge_vals[i], edge_vals[5 - i], 32'h1};
      send_point(pt);
    end
    pt = '{32'h1, 32'h0, 32'h0};
    send_point(pt);
    drain();
    write_reg(8, 64'hdead_beef_dead_beef);
    write_reg(15, '0);

    for (int phase = 0; phase < 8; phase++) begin
      for (int r = 0; r < NumRegs; r++) write_reg(r, {rand_entry(), rand_entry()});
      if ($urandom_range(1)) write_reg(7, {32'h10000, rand_entry()});
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      random_points(100);
      drain();
      random_points(100);
      drain();
    end

    // Back to the identity matrix for a final batch.
    for (int r = 0; r < NumRegs; r++) write_reg(r, RegReset[r]);
    send_idle_pct = 17;
    recv_stall_pct = 17;
    random_points(100);
    drain();

    if (board.fail_count == 0 && board.pending_screen.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
